>>> rtl/core/rv64i_iex_pkg.sv
// types and operation codes for the rv64i integer execute unit
package rv64i_iex_pkg;

  localparam int XLEN     = 64;
  localparam int NUM_REGS = 32;

  typedef enum logic [5:0] {
    OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3,
    OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLT = 6'd6, OP_BGE = 6'd7,
    OP_BLTU = 6'd8, OP_BGEU = 6'd9,
    OP_LB = 6'd10, OP_LH = 6'd11, OP_LW = 6'd12, OP_LBU = 6'd13, OP_LHU = 6'd14,
    OP_SB = 6'd15, OP_SH = 6'd16, OP_SW = 6'd17,
    OP_ADDI = 6'd18, OP_SLTI = 6'd19, OP_SLTIU = 6'd20, OP_XORI = 6'd21,
    OP_ORI = 6'd22, OP_ANDI = 6'd23, OP_SLLI = 6'd24, OP_SRLI = 6'd25,
    OP_SRAI = 6'd26,
    OP_ADD = 6'd27, OP_SUB = 6'd28, OP_SLL = 6'd29, OP_SLT = 6'd30,
    OP_SLTU = 6'd31, OP_XOR = 6'd32, OP_SRL = 6'd33, OP_SRA = 6'd34,
    OP_OR = 6'd35, OP_AND = 6'd36,
    OP_FENCE = 6'd37, OP_ECALL = 6'd38, OP_EBREAK = 6'd39,
    OP_LWU = 6'd40, OP_LD = 6'd41, OP_SD = 6'd42,
    OP_ADDIW = 6'd43, OP_SLLIW = 6'd44, OP_SRLIW = 6'd45, OP_SRAIW = 6'd46,
    OP_ADDW = 6'd47, OP_SUBW = 6'd48, OP_SLLW = 6'd49, OP_SRLW = 6'd50,
    OP_SRAW = 6'd51,
    OP_DONE = 6'd52
  } cmd_t;

  localparam logic [2:0] TRAP_NONE      = 3'd0;
  localparam logic [2:0] TRAP_MISALIGN  = 3'd1;
  localparam logic [2:0] TRAP_ECALL_U   = 3'd2;
  localparam logic [2:0] TRAP_ECALL_S   = 3'd3;
  localparam logic [2:0] TRAP_ECALL_M   = 3'd4;
  localparam logic [2:0] TRAP_BREAK     = 3'd5;
  localparam logic [2:0] TRAP_LD_FAULT  = 3'd6;
  localparam logic [2:0] TRAP_ST_FAULT  = 3'd7;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  localparam logic [1:0] SZ_B = 2'd0;
  localparam logic [1:0] SZ_H = 2'd1;
  localparam logic [1:0] SZ_W = 2'd2;
  localparam logic [1:0] SZ_D = 2'd3;

  typedef struct packed {
    logic [5:0]         command;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [63:0]        current_pc;
    logic [1:0]         privilege_mode;
    logic [63:0]        access_data;
    logic               access_ok;
  } in_item_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic [2:0]  trap_cause;
    logic [63:0] trap_value;
    logic [1:0]  mem_request;
    logic [63:0] mem_address;
    logic [1:0]  mem_size;
    logic [63:0] mem_write_data;
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [63:0] written_value;
  } out_item_t;

endpackage

>>> rtl/core/rv64i_integer_execute_unit.sv
// rv64i integer execute unit: register file, alu, branch and load/store issue
// the input is held in the operand register, then the result in the result register
// throughput: one item per cycle unless out_ready stalls the output; the register file is read
// at transfer with forwarding from the item in execute, so dependent items follow back to back
// reset: synchronous active-low rst_n clears all valid flags, the register file
// valid bits and the pending access state; the register file reads as zero after reset
module rv64i_integer_execute_unit
  import rv64i_iex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IW = $clog2(NUM_REGS);

  logic [XLEN-1:0] rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;

  logic            s1_valid_r;
  in_item_t        s1_r;
  logic [XLEN-1:0] rd1_r, rd2_r, byp_val_r;
  logic            vld1_r, vld2_r, byp1_r, byp2_r;

  logic            pend_ld_r, pend_st_r, pend_sgn_r;
  logic [4:0]      pend_dest_r;
  logic [1:0]      pend_size_r;
  logic [63:0]     pend_addr_r;

  logic            out_valid_r;
  out_item_t       out_r;

  logic      adv, in_xfer, fire;
  out_item_t res;
  logic      wr_en;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_xfer  = in_valid && in_ready;
  assign fire     = s1_valid_r && adv;
  assign wr_en    = fire && res.reg_written;

  logic [63:0] a, b, imm, pc4, sum_ai, tgt, ld_val, alu_w;
  logic        jump, link, wr;
  logic [4:0]  rd;
  logic [5:0]  shamt_i, shamt_r;
  cmd_t        cmd;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] ext_ld(input logic [63:0] v, input logic [1:0] sz,
                                         input logic sgn);
    logic [63:0] r;
    case (sz)
      SZ_B:    r = {{56{sgn & v[7]}}, v[7:0]};
      SZ_H:    r = {{48{sgn & v[15]}}, v[15:0]};
      SZ_W:    r = {{32{sgn & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    a = (s1_r.src1_reg == 5'd0) ? 64'd0 : byp1_r ? byp_val_r[63:0] :
        vld1_r ? rd1_r[63:0] : 64'd0;
    b = (s1_r.src2_reg == 5'd0) ? 64'd0 : byp2_r ? byp_val_r[63:0] :
        vld2_r ? rd2_r[63:0] : 64'd0;
  end

  always_comb begin
    cmd     = cmd_t'(s1_r.command);
    imm     = sx32(s1_r.immediate);
    pc4     = s1_r.current_pc + 64'd4;
    sum_ai  = a + imm;
    shamt_i = s1_r.immediate[5:0];
    shamt_r = b[5:0];
    ld_val  = ext_ld(s1_r.access_data, pend_size_r, pend_sgn_r);
    alu_w   = 64'd0;
    res     = '0;
    res.next_pc = pc4;
    jump = 1'b0;
    link = 1'b0;
    wr   = 1'b0;
    rd   = s1_r.dest_reg;
    tgt  = s1_r.current_pc + imm;
    case (cmd)
      OP_LUI:   begin
        alu_w = {{32{s1_r.immediate[19]}}, s1_r.immediate[19:0], 12'd0};
        wr = 1'b1;
      end
      OP_AUIPC: begin
        alu_w = s1_r.current_pc + {{32{s1_r.immediate[19]}}, s1_r.immediate[19:0], 12'd0};
        wr = 1'b1;
      end
      OP_JAL:   begin jump = 1'b1; link = 1'b1; end
      OP_JALR:  begin tgt = {sum_ai[63:1], 1'b0}; jump = 1'b1; link = 1'b1; end
      OP_BEQ:   jump = (a == b);
      OP_BNE:   jump = (a != b);
      OP_BLT:   jump = ($signed(a) < $signed(b));
      OP_BGE:   jump = !($signed(a) < $signed(b));
      OP_BLTU:  jump = (a < b);
      OP_BGEU:  jump = (a >= b);
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWU, OP_LD: begin
        res.mem_request = REQ_READ;
        res.mem_address = sum_ai;
        case (cmd)
          OP_LB, OP_LBU: res.mem_size = SZ_B;
          OP_LH, OP_LHU: res.mem_size = SZ_H;
          OP_LD:         res.mem_size = SZ_D;
          default:       res.mem_size = SZ_W;
        endcase
      end
      OP_SB, OP_SH, OP_SW, OP_SD: begin
        res.mem_request    = REQ_WRITE;
        res.mem_address    = sum_ai;
        res.mem_write_data = b;
        case (cmd)
          OP_SB:   res.mem_size = SZ_B;
          OP_SH:   res.mem_size = SZ_H;
          OP_SW:   res.mem_size = SZ_W;
          default: res.mem_size = SZ_D;
        endcase
      end
      OP_ADDI:  begin alu_w = sum_ai; wr = 1'b1; end
      OP_SLTI:  begin alu_w = {63'd0, $signed(a) < $signed(imm)}; wr = 1'b1; end
      OP_SLTIU: begin alu_w = {63'd0, a < imm}; wr = 1'b1; end
      OP_XORI:  begin alu_w = a ^ imm; wr = 1'b1; end
      OP_ORI:   begin alu_w = a | imm; wr = 1'b1; end
      OP_ANDI:  begin alu_w = a & imm; wr = 1'b1; end
      OP_SLLI:  begin alu_w = a << shamt_i; wr = 1'b1; end
      OP_SRLI:  begin alu_w = a >> shamt_i; wr = 1'b1; end
      OP_SRAI:  begin alu_w = $unsigned($signed(a) >>> shamt_i); wr = 1'b1; end
      OP_ADD:   begin alu_w = a + b; wr = 1'b1; end
      OP_SUB:   begin alu_w = a - b; wr = 1'b1; end
      OP_SLL:   begin alu_w = a << shamt_r; wr = 1'b1; end
      OP_SLT:   begin alu_w = {63'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
      OP_SLTU:  begin alu_w = {63'd0, a < b}; wr = 1'b1; end
      OP_XOR:   begin alu_w = a ^ b; wr = 1'b1; end
      OP_SRL:   begin alu_w = a >> shamt_r; wr = 1'b1; end
      OP_SRA:   begin alu_w = $unsigned($signed(a) >>> shamt_r); wr = 1'b1; end
      OP_OR:    begin alu_w = a | b; wr = 1'b1; end
      OP_AND:   begin alu_w = a & b; wr = 1'b1; end
      OP_FENCE: ;
      OP_ECALL: begin
        case (s1_r.privilege_mode)
          PRIV_U:  res.trap_cause = TRAP_ECALL_U;
          PRIV_S:  res.trap_cause = TRAP_ECALL_S;
          PRIV_M:  res.trap_cause = TRAP_ECALL_M;
          default: res.trap_cause = TRAP_NONE;
        endcase
      end
      OP_EBREAK: begin res.trap_cause = TRAP_BREAK; res.trap_value = s1_r.current_pc; end
      OP_ADDIW: begin alu_w = sx32(sum_ai[31:0]); wr = 1'b1; end
      OP_SLLIW: begin alu_w = sx32(a[31:0] << shamt_i[4:0]); wr = 1'b1; end
      OP_SRLIW: begin alu_w = sx32(a[31:0] >> shamt_i[4:0]); wr = 1'b1; end
      OP_SRAIW: begin alu_w = sx32($unsigned($signed(a[31:0]) >>> shamt_i[4:0])); wr = 1'b1; end
      OP_ADDW:  begin alu_w = sx32(a[31:0] + b[31:0]); wr = 1'b1; end
      OP_SUBW:  begin alu_w = sx32(a[31:0] - b[31:0]); wr = 1'b1; end
      OP_SLLW:  begin alu_w = sx32(a[31:0] << shamt_r[4:0]); wr = 1'b1; end
      OP_SRLW:  begin alu_w = sx32(a[31:0] >> shamt_r[4:0]); wr = 1'b1; end
      OP_SRAW:  begin alu_w = sx32($unsigned($signed(a[31:0]) >>> shamt_r[4:0])); wr = 1'b1; end
      OP_DONE: begin
        res.next_pc = s1_r.current_pc;
        if (pend_ld_r) begin
          if (s1_r.access_ok) begin
            rd    = pend_dest_r;
            alu_w = ld_val;
            wr    = 1'b1;
          end else begin
            res.trap_cause = TRAP_LD_FAULT;
            res.trap_value = pend_addr_r;
          end
        end else if (pend_st_r && !s1_r.access_ok) begin
          res.trap_cause = TRAP_ST_FAULT;
          res.trap_value = pend_addr_r;
        end
      end
      default: ;
    endcase

    if (jump) begin
      if (tgt[1:0] != 2'b00) begin
        res.trap_cause = TRAP_MISALIGN;
        res.trap_value = tgt;
      end else begin
        res.next_pc = tgt;
        if (link) begin
          alu_w = pc4;
          wr    = 1'b1;
        end
      end
    end
    if (res.trap_cause != TRAP_NONE) begin
      res.next_pc = s1_r.current_pc;
      wr = 1'b0;
    end
    if (wr && rd != 5'd0) begin
      res.reg_written   = 1'b1;
      res.written_reg   = rd;
      res.written_value = alu_w;
    end
  end

  // register file with registered read and forwarding from execute
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[res.written_reg[IW-1:0]] <= XLEN'(res.written_value);
    end
    if (in_xfer) begin
      rd1_r     <= rf_mem[in_data.src1_reg[IW-1:0]];
      rd2_r     <= rf_mem[in_data.src2_reg[IW-1:0]];
      vld1_r    <= rf_vld_r[in_data.src1_reg[IW-1:0]];
      vld2_r    <= rf_vld_r[in_data.src2_reg[IW-1:0]];
      byp1_r    <= wr_en && (res.written_reg == in_data.src1_reg);
      byp2_r    <= wr_en && (res.written_reg == in_data.src2_reg);
      byp_val_r <= XLEN'(res.written_value);
      s1_r      <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_ld_r   <= 1'b0;
      pend_st_r   <= 1'b0;
      pend_sgn_r  <= 1'b0;
      pend_dest_r <= '0;
      pend_size_r <= '0;
      pend_addr_r <= '0;
    end else begin
      if (wr_en) begin
        rf_vld_r[res.written_reg[IW-1:0]] <= 1'b1;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire) begin
        if (res.mem_request == REQ_READ) begin
          pend_ld_r   <= 1'b1;
          pend_st_r   <= 1'b0;
          pend_dest_r <= s1_r.dest_reg;
          pend_size_r <= res.mem_size;
          pend_sgn_r  <= (cmd == OP_LB) || (cmd == OP_LH) || (cmd == OP_LW);
          pend_addr_r <= res.mem_address;
        end else if (res.mem_request == REQ_WRITE) begin
          pend_ld_r   <= 1'b0;
          pend_st_r   <= 1'b1;
          pend_dest_r <= '0;
          pend_size_r <= res.mem_size;
          pend_sgn_r  <= 1'b0;
          pend_addr_r <= res.mem_address;
        end else if (cmd == OP_DONE) begin
          pend_ld_r <= 1'b0;
          pend_st_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reg_written |-> out_data.written_reg != 5'd0)
    else $error("write to x0 reported");
  a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.trap_cause != TRAP_NONE |-> !out_data.reg_written)
    else $error("register written on trap");
  a_req_no_trap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mem_request != REQ_NONE |-> out_data.trap_cause == TRAP_NONE)
    else $error("memory request with trap");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_r))
    else $error("execute item lost under stall");
`endif

endmodule
